/* sv/hbc_pkg.sv */
// ----------------------------------------------------------------------------
// hbc_pkg
// types and constants shared by the hsv to bgr pixel converter stages
// ----------------------------------------------------------------------------
package hbc_pkg;

    typedef logic [2:0] t_sector;

    localparam t_sector SECT_0 = 3'd0;
    localparam t_sector SECT_1 = 3'd1;
    localparam t_sector SECT_2 = 3'd2;
    localparam t_sector SECT_3 = 3'd3;
    localparam t_sector SECT_4 = 3'd4;
    localparam t_sector SECT_5 = 3'd5;

    // sector width in half hue steps, full level and the q/t denominator
    localparam logic [6:0]  SECTOR_DEN = 7'd85;
    localparam logic [7:0]  FULL_LEVEL = 8'd255;
    localparam logic [14:0] QT_DEN     = 15'd21675;

    // rounding divisors (twice the denominators) and rounded-up reciprocals
    localparam logic [8:0]  P_DEN2   = 9'd510;
    localparam logic [15:0] QT_DEN2  = 16'd43350;
    localparam int          P_SHIFT  = 26;
    localparam int          QT_SHIFT = 40;
    localparam logic [17:0] P_RECIP  =
        18'(((64'd1 << P_SHIFT) + 64'(P_DEN2) - 64'd1) / 64'(P_DEN2));
    localparam logic [24:0] QT_RECIP =
        25'(((64'd1 << QT_SHIFT) + 64'(QT_DEN2) - 64'd1) / 64'(QT_DEN2));

    typedef struct packed {
        t_sector    sector;
        logic [6:0] fr;
        logic [7:0] sat;
        logic [7:0] val;
    } t_sec_data;

    typedef struct packed {
        t_sector     sector;
        logic [7:0]  val;
        logic [15:0] num_p;
        logic [14:0] sf_q;
        logic [14:0] sf_t;
    } t_prod_data;

    typedef struct packed {
        t_sector     sector;
        logic [7:0]  val;
        logic [15:0] num_p;
        logic [22:0] num_q;
        logic [22:0] num_t;
    } t_num_data;

    typedef struct packed {
        t_sector    sector;
        logic [7:0] val;
        logic [7:0] lvl_p;
        logic [7:0] lvl_q;
        logic [7:0] lvl_t;
    } t_lvl_data;

endpackage

/* sv/hbc_sector.sv */
// ----------------------------------------------------------------------------
// hbc_sector
// splits the hue into a sector and the remainder inside it
// ----------------------------------------------------------------------------
module hbc_sector
    import hbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_saturation,
    input  logic [7:0] i_brightness,
    output logic       o_valid,
    input  logic       i_ready,
    output t_sec_data  o_data
);

    logic       r_vld;
    t_sec_data  r_data;
    t_sec_data  n_data;
    logic [8:0] h2;
    logic [8:0] base;

    assign o_ready = !r_vld || i_ready;
    assign h2      = {i_hue, 1'b0};

    always_comb begin
        n_data.sat = i_saturation;
        n_data.val = i_brightness;
        base       = 9'd0;
        // top of the hue range wraps to the start of sector zero
        if (h2 >= 9'd510) begin
            n_data.sector = SECT_0;
            base          = h2;
        end else if (h2 >= 9'd425) begin
            n_data.sector = SECT_5;
            base          = 9'd425;
        end else if (h2 >= 9'd340) begin
            n_data.sector = SECT_4;
            base          = 9'd340;
        end else if (h2 >= 9'd255) begin
            n_data.sector = SECT_3;
            base          = 9'd255;
        end else if (h2 >= 9'd170) begin
            n_data.sector = SECT_2;
            base          = 9'd170;
        end else if (h2 >= 9'd85) begin
            n_data.sector = SECT_1;
            base          = 9'd85;
        end else begin
            n_data.sector = SECT_0;
        end
        n_data.fr = 7'(h2 - base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

/* sv/hbc_mult.sv */
// ----------------------------------------------------------------------------
// hbc_mult
// two multiplier stages forming the p, q and t numerators
// ----------------------------------------------------------------------------
module hbc_mult
    import hbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_sec_data  i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_num_data  o_data
);

    logic       r_vld1;
    logic       r_vld2;
    logic       rdy1;
    logic       rdy2;
    t_prod_data r_prod;
    t_prod_data n_prod;
    t_num_data  r_num;
    t_num_data  n_num;
    logic [7:0] inv_sat;
    logic [6:0] inv_fr;

    assign rdy2    = !r_vld2 || i_ready;
    assign rdy1    = !r_vld1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        inv_sat       = FULL_LEVEL - i_data.sat;
        inv_fr        = SECTOR_DEN - i_data.fr;
        n_prod.sector = i_data.sector;
        n_prod.val    = i_data.val;
        n_prod.num_p  = i_data.val * inv_sat;
        n_prod.sf_q   = 15'(i_data.sat * i_data.fr);
        n_prod.sf_t   = 15'(i_data.sat * inv_fr);
    end

    always_comb begin
        n_num.sector = r_prod.sector;
        n_num.val    = r_prod.val;
        n_num.num_p  = r_prod.num_p;
        n_num.num_q  = r_prod.val * (QT_DEN - r_prod.sf_q);
        n_num.num_t  = r_prod.val * (QT_DEN - r_prod.sf_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_vld1 <= i_valid;
            end
            if (rdy2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_prod <= n_prod;
        end
        if (rdy2 && r_vld1) begin
            r_num <= n_num;
        end
    end

    assign o_valid = r_vld2;
    assign o_data  = r_num;

endmodule

/* sv/hbc_scale.sv */
// ----------------------------------------------------------------------------
// hbc_scale
// rounded division of the numerators by reciprocal multiplication
// ----------------------------------------------------------------------------
module hbc_scale
    import hbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_num_data  i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_lvl_data  o_data
);

    logic        r_vld;
    t_lvl_data   r_data;
    t_lvl_data   n_data;
    logic [16:0] rnd_p;
    logic [23:0] rnd_q;
    logic [23:0] rnd_t;
    logic [34:0] prod_p;
    logic [48:0] prod_q;
    logic [48:0] prod_t;

    assign o_ready = !r_vld || i_ready;

    // round to nearest, ties up: (2n + d) / 2d, exact for these operand ranges
    always_comb begin
        rnd_p  = {i_data.num_p, 1'b0} + 17'(FULL_LEVEL);
        rnd_q  = {i_data.num_q, 1'b0} + 24'(QT_DEN);
        rnd_t  = {i_data.num_t, 1'b0} + 24'(QT_DEN);
        prod_p = rnd_p * P_RECIP;
        prod_q = rnd_q * QT_RECIP;
        prod_t = rnd_t * QT_RECIP;
        n_data.sector = i_data.sector;
        n_data.val    = i_data.val;
        n_data.lvl_p  = prod_p[P_SHIFT +: 8];
        n_data.lvl_q  = prod_q[QT_SHIFT +: 8];
        n_data.lvl_t  = prod_t[QT_SHIFT +: 8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

/* sv/hsv_to_bgr_pixel_convert_core.sv */
// ----------------------------------------------------------------------------
// hsv_to_bgr_pixel_convert_core
// pipelined conversion of 8-bit hue, saturation, value pixels to bgr bytes
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  input    i_valid o_ready i_hue i_saturation         in
//           i_brightness
//  output   o_valid i_ready o_blue o_green o_red      out
//
//  one transaction accepted per cycle while the output is not stalled; five
//  register stages (sector split, two multiplier stages, reciprocal scaling,
//  channel select) lie between an accepted pixel and the output
//  each stage holds its data while the next one is stalled; bubbles close up
//  synchronous active-low reset clears the valid bits only
// ----------------------------------------------------------------------------
module hsv_to_bgr_pixel_convert_core
    import hbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_saturation,
    input  logic [7:0] i_brightness,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_blue,
    output logic [7:0] o_green,
    output logic [7:0] o_red
);

    logic       sec_vld;
    logic       sec_rdy;
    t_sec_data  sec_data;
    logic       num_vld;
    logic       num_rdy;
    t_num_data  num_data;
    logic       lvl_vld;
    logic       lvl_rdy;
    t_lvl_data  lvl_data;
    logic       r_vld;
    logic [7:0] r_blue;
    logic [7:0] r_green;
    logic [7:0] r_red;
    logic [7:0] n_blue;
    logic [7:0] n_green;
    logic [7:0] n_red;

    hbc_sector u_sector (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (sec_vld),
        .i_ready      (sec_rdy),
        .o_data       (sec_data)
    );

    hbc_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sec_vld),
        .o_ready (sec_rdy),
        .i_data  (sec_data),
        .o_valid (num_vld),
        .i_ready (num_rdy),
        .o_data  (num_data)
    );

    hbc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (num_vld),
        .o_ready (num_rdy),
        .i_data  (num_data),
        .o_valid (lvl_vld),
        .i_ready (lvl_rdy),
        .o_data  (lvl_data)
    );

    assign lvl_rdy = !r_vld || i_ready;

    always_comb begin
        case (lvl_data.sector)
            SECT_0: begin
                n_blue  = lvl_data.lvl_p;
                n_green = lvl_data.lvl_t;
                n_red   = lvl_data.val;
            end
            SECT_1: begin
                n_blue  = lvl_data.lvl_p;
                n_green = lvl_data.val;
                n_red   = lvl_data.lvl_q;
            end
            SECT_2: begin
                n_blue  = lvl_data.lvl_t;
                n_green = lvl_data.val;
                n_red   = lvl_data.lvl_p;
            end
            SECT_3: begin
                n_blue  = lvl_data.val;
                n_green = lvl_data.lvl_q;
                n_red   = lvl_data.lvl_p;
            end
            SECT_4: begin
                n_blue  = lvl_data.val;
                n_green = lvl_data.lvl_p;
                n_red   = lvl_data.lvl_t;
            end
            default: begin
                n_blue  = lvl_data.lvl_q;
                n_green = lvl_data.lvl_p;
                n_red   = lvl_data.val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (lvl_rdy) begin
            r_vld <= lvl_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lvl_rdy && lvl_vld) begin
            r_blue  <= n_blue;
            r_green <= n_green;
            r_red   <= n_red;
        end
    end

    assign o_valid = r_vld;
    assign o_blue  = r_blue;
    assign o_green = r_green;
    assign o_red   = r_red;

endmodule

/* tb/tb_hsv_to_bgr_pixel_convert_core.sv */
// ----------------------------------------------------------------------------
// tb_hsv_to_bgr_pixel_convert_core
// self-checking bench: hsv pixels in, predicted bgr bytes compared in order
// ----------------------------------------------------------------------------
// A directed table of pixels comes first: the hue sector edges, the top hue
// that wraps into the first sector, and the zero and full levels. After that,
// random pixels are sent. Every pixel the core takes has its bgr bytes worked
// out here, and each result the core gives is compared with the oldest one.
// Both sides of the core go idle at random, except in one quiet window.
// ----------------------------------------------------------------------------
module tb_hsv_to_bgr_pixel_convert_core;
    import hbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_ITEMS = 930;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 16;
    localparam int QUIET_START  = 200;
    localparam int QUIET_STOP   = 500;
    localparam int N_ROWS       = 21;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_bgr;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic       typed;
        t_bgr       want;
    } t_pixel_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_hue;
    logic [7:0] i_saturation;
    logic [7:0] i_brightness;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_blue;
    logic [7:0] o_green;
    logic [7:0] o_red;

    t_bgr pending_bgr[$];
    t_bgr next_bgr;
    int   mismatch_count = 0;
    int   cycle_count = 0;

    // bgr bytes expected only where they follow directly from the inputs
    t_pixel_row directed_rows [N_ROWS] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{8'd128, 8'd0,   8'd200, 1'b1, '{8'd200, 8'd200, 8'd200}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
        '{8'd77,  8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
        '{8'd42,  8'd255, 8'd255, 1'b0, '0},
        '{8'd43,  8'd255, 8'd255, 1'b0, '0},
        '{8'd85,  8'd200, 8'd180, 1'b0, '0},
        '{8'd127, 8'd255, 8'd255, 1'b0, '0},
        '{8'd128, 8'd255, 8'd255, 1'b0, '0},
        '{8'd170, 8'd150, 8'd240, 1'b0, '0},
        '{8'd212, 8'd255, 8'd255, 1'b0, '0},
        '{8'd213, 8'd255, 8'd255, 1'b0, '0},
        '{8'd254, 8'd255, 8'd255, 1'b0, '0},
        '{8'd255, 8'd128, 8'd100, 1'b0, '0},
        '{8'd21,  8'd1,   8'd1,   1'b0, '0},
        '{8'd106, 8'd254, 8'd254, 1'b0, '0},
        '{8'd191, 8'd127, 8'd128, 1'b0, '0},
        '{8'd255, 8'd255, 8'd1,   1'b0, '0}
    };

    hsv_to_bgr_pixel_convert_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_blue       (o_blue),
        .o_green      (o_green),
        .o_red        (o_red)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // round num/den to nearest, ties up
    function automatic logic [7:0] round_level(int unsigned num, int unsigned den);
        return 8'((2 * num + den) / (2 * den));
    endfunction

    function automatic t_bgr predict_bgr(logic [7:0] hue, logic [7:0] sat,
                                         logic [7:0] val);
        int unsigned hue2;
        int unsigned sect_idx;
        int unsigned frac;
        int unsigned s;
        int unsigned v;
        t_sector     sector;
        logic [7:0]  lvl_p;
        logic [7:0]  lvl_q;
        logic [7:0]  lvl_t;
        t_bgr        res;
        hue2     = 2 * int'(hue);
        sect_idx = hue2 / SECTOR_DEN;
        frac     = hue2 - SECTOR_DEN * sect_idx;
        s        = sat;
        v        = val;
        // top hue lands past the last sector and wraps to the first
        if (sect_idx >= 6) begin
            sect_idx = 0;
            frac     = 0;
        end
        sector = t_sector'(sect_idx);
        lvl_p = round_level(v * (FULL_LEVEL - s), FULL_LEVEL);
        lvl_q = round_level(v * (QT_DEN - s * frac), QT_DEN);
        lvl_t = round_level(v * (QT_DEN - s * (SECTOR_DEN - frac)), QT_DEN);
        case (sector)
            SECT_0: res = '{lvl_p, lvl_t, val};
            SECT_1: res = '{lvl_p, val, lvl_q};
            SECT_2: res = '{lvl_t, val, lvl_p};
            SECT_3: res = '{val, lvl_q, lvl_p};
            SECT_4: res = '{val, lvl_p, lvl_t};
            default: res = '{lvl_q, lvl_p, val};
        endcase
        return res;
    endfunction

    function automatic bit quiet_window();
        return cycle_count >= QUIET_START && cycle_count < QUIET_STOP;
    endfunction

    function automatic int idle_gap();
        int gap;
        gap = 0;
        if (!quiet_window()) begin
            while ($urandom_range(99) < IDLE_PCT && gap < 12) gap++;
        end
        return gap;
    endfunction

    task automatic send_pixel(logic [7:0] hue, logic [7:0] sat, logic [7:0] val,
                              t_bgr want);
        int gap;
        gap = idle_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        next_bgr     = want;
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= val;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        while (pending_bgr.size() != 0) @(posedge i_clk);
    endtask

    // receiver side: stalls at random outside the quiet window
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet_window() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hsv_to_bgr_pixel_convert_core regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_bgr exp_bgr;
        if (i_rst_n) begin
            if (i_valid && o_ready) pending_bgr.push_back(next_bgr);
            if (o_valid && i_ready) begin
                if (pending_bgr.size() == 0) begin
                    $error("unexpected transaction: blue %0d green %0d red %0d",
                           o_blue, o_green, o_red);
                    mismatch_count++;
                end else begin
                    exp_bgr = pending_bgr.pop_front();
                    if (o_blue !== exp_bgr.blue) begin
                        $error("blue expected %0d actual %0d", exp_bgr.blue, o_blue);
                        mismatch_count++;
                    end
                    if (o_green !== exp_bgr.green) begin
                        $error("green expected %0d actual %0d", exp_bgr.green, o_green);
                        mismatch_count++;
                    end
                    if (o_red !== exp_bgr.red) begin
                        $error("red expected %0d actual %0d", exp_bgr.red, o_red);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        t_bgr       want;
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        int         drain;
        next_bgr       = '0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_hue          = 8'd0;
        i_saturation   = 8'd0;
        i_brightness   = 8'd0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].typed) want = directed_rows[k].want;
            else want = predict_bgr(directed_rows[k].hue, directed_rows[k].sat,
                                    directed_rows[k].val);
            send_pixel(directed_rows[k].hue, directed_rows[k].sat,
                       directed_rows[k].val, want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // sender holds off until the pipeline has emptied
            if (n == RANDOM_ITEMS / 2) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                wait_drained();
            end
            hue = 8'($urandom_range(255));
            sat = 8'($urandom_range(255));
            val = 8'($urandom_range(255));
            // lean on sector edges and the zero and full levels now and then
            case ($urandom_range(9))
                0: hue = ($urandom_range(1)) ? 8'd255 : 8'd0;
                1: hue = 8'(42 + 43 * $urandom_range(4) + $urandom_range(1));
                2: sat = ($urandom_range(1)) ? 8'd255 : 8'd0;
                3: val = ($urandom_range(1)) ? 8'd255 : 8'd0;
                default: ;
            endcase
            send_pixel(hue, sat, val, predict_bgr(hue, sat, val));
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        wait_drained();
        drain = 0;
        while (drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end

        if (pending_bgr.size() != 0) begin
            $error("%0d expected transactions never arrived", pending_bgr.size());
        end
        if (mismatch_count == 0 && pending_bgr.size() == 0) begin
            $display("hsv_to_bgr_pixel_convert_core regression: pass");
        end else begin
            $display("hsv_to_bgr_pixel_convert_core regression: fail");
        end
        $finish;
    end

endmodule
